@@ rtl/rlsw_pkg.sv @@
// Package for the RGB LED serial waveform block: widths, reset values,
// register offsets. No dependencies.
package rlsw_pkg;

    localparam int BITS_PER_LED = 24;
    localparam int RGB_W        = 24;
    localparam int CNT_W        = $clog2(BITS_PER_LED + 1);
    localparam int CFG_W        = 16;
    localparam int PADDR_W      = 4;
    localparam int PDATA_W      = 32;

    localparam logic [CFG_W-1:0] PERIOD_RST = CFG_W'(120);
    localparam logic [CFG_W-1:0] ZERO_RST   = CFG_W'(30);
    localparam logic [CFG_W-1:0] ONE_RST    = CFG_W'(90);

    localparam logic [1:0] REG_PERIOD_LEN = 2'd0;
    localparam logic [1:0] REG_ZERO_HIGH  = 2'd1;
    localparam logic [1:0] REG_ONE_HIGH   = 2'd2;

    localparam logic MODE_LOAD = 1'b1;

endpackage

@@ rtl/rlsw_if.sv @@
// Stream interfaces for the waveform block: input tick channel and result channel.
// Depends on nothing.
interface rlsw_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output mode, output red, output green, output blue,
                    input ready);
    modport sink   (input valid, input mode, input red, input green, input blue,
                    output ready);
endinterface

interface rlsw_res_if;
    logic valid;
    logic ready;
    logic line_level;
    logic busy_res;
    logic load_rejected;

    modport source (output valid, output line_level, output busy_res,
                    output load_rejected, input ready);
    modport sink   (input valid, input line_level, input busy_res,
                    input load_rejected, output ready);
endinterface

@@ rtl/rgb_led_serial_waveform.sv @@
// Top level of the RGB LED serial waveform generator: APB config, tick state, result skid.
// Depends on rlsw_pkg and the interfaces in rlsw_if.sv.
// The result of a transaction is registered in the output register, or in the skid entry while the output stalls.
// Throughput: one transaction per cycle while the skid entry is empty; an output register plus
// one skid entry keep input ready while a single result waits downstream.
// Reset (synchronous, active low): state idle, counters and colour cleared,
// registers back to 120/30/90, no result pending.
module rgb_led_serial_waveform (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rlsw_pkg::PADDR_W-1:0]      paddr,
    input  logic [rlsw_pkg::PDATA_W-1:0]      pwdata,
    output logic [rlsw_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready,
    rlsw_in_if.sink                           i_in_if,
    rlsw_res_if.source                        o_res_if
);

    localparam int W = rlsw_pkg::BITS_PER_LED;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LEAD,
        PH_BITS
    } t_phase;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic load_rejected;
    } t_res;

    logic [rlsw_pkg::CFG_W-1:0] r_period, r_zero, r_one;
    logic                       cfg_wr;
    logic [1:0]                 reg_idx;

    t_phase                     r_phase, n_phase, eff_phase;
    logic [W-1:0]               r_colour, n_colour, eff_colour, load_colour;
    logic [rlsw_pkg::CNT_W-1:0] r_bits, n_bits, eff_bits, bits_dec;
    logic [rlsw_pkg::CFG_W-1:0] r_tick, n_tick, eff_tick, tick_inc;
    logic [rlsw_pkg::CFG_W:0]   tick_next;
    logic                       period_end;
    logic                       load_ok;
    logic [rlsw_pkg::CFG_W-1:0] high_len;
    t_res                       res;

    t_res r_out, r_skid;
    logic r_out_valid, r_skid_valid;
    logic in_fire;

    // Config port
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        case (reg_idx)
            rlsw_pkg::REG_PERIOD_LEN: prdata = rlsw_pkg::PDATA_W'(r_period);
            rlsw_pkg::REG_ZERO_HIGH:  prdata = rlsw_pkg::PDATA_W'(r_zero);
            rlsw_pkg::REG_ONE_HIGH:   prdata = rlsw_pkg::PDATA_W'(r_one);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= rlsw_pkg::PERIOD_RST;
            r_zero   <= rlsw_pkg::ZERO_RST;
            r_one    <= rlsw_pkg::ONE_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                rlsw_pkg::REG_PERIOD_LEN: r_period <= pwdata[rlsw_pkg::CFG_W-1:0];
                rlsw_pkg::REG_ZERO_HIGH:  r_zero   <= pwdata[rlsw_pkg::CFG_W-1:0];
                rlsw_pkg::REG_ONE_HIGH:   r_one    <= pwdata[rlsw_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Tick logic
    assign in_fire     = i_in_if.valid && i_in_if.ready;
    assign load_colour = W'({i_in_if.red, i_in_if.green, i_in_if.blue});
    assign load_ok     = (i_in_if.mode == rlsw_pkg::MODE_LOAD) && (r_phase == PH_IDLE);

    assign eff_phase  = load_ok ? PH_LEAD : r_phase;
    assign eff_colour = load_ok ? load_colour : r_colour;
    assign eff_bits   = load_ok ? rlsw_pkg::CNT_W'(W) : r_bits;
    assign eff_tick   = load_ok ? '0 : r_tick;

    assign tick_next  = {1'b0, eff_tick} + 1'b1;
    assign period_end = tick_next >= {1'b0, r_period};
    assign tick_inc   = period_end ? '0 : tick_next[rlsw_pkg::CFG_W-1:0];
    assign bits_dec   = eff_bits - 1'b1;
    assign high_len   = eff_colour[W-1] ? r_one : r_zero;

    always_comb begin
        n_phase  = eff_phase;
        n_colour = eff_colour;
        n_bits   = eff_bits;
        n_tick   = eff_tick;
        res.line_level    = 1'b0;
        res.busy_res      = 1'b0;
        res.load_rejected = (i_in_if.mode == rlsw_pkg::MODE_LOAD) && !load_ok;
        case (eff_phase)
            PH_LEAD: begin
                res.busy_res = 1'b1;
                n_tick       = tick_inc;
                if (period_end) begin
                    n_phase = PH_BITS;
                end
            end
            PH_BITS: begin
                res.busy_res   = 1'b1;
                res.line_level = eff_tick < high_len;
                n_tick         = tick_inc;
                if (period_end) begin
                    n_bits   = bits_dec;
                    n_colour = {eff_colour[W-2:0], 1'b0};
                    if (bits_dec == '0) begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_colour <= '0;
            r_bits   <= '0;
            r_tick   <= '0;
        end else if (in_fire) begin
            r_phase  <= n_phase;
            r_colour <= n_colour;
            r_bits   <= n_bits;
            r_tick   <= n_tick;
        end
    end

    // Result register with one skid entry
    assign i_in_if.ready          = !r_skid_valid;
    assign o_res_if.valid         = r_out_valid;
    assign o_res_if.line_level    = r_out.line_level;
    assign o_res_if.busy_res      = r_out.busy_res;
    assign o_res_if.load_rejected = r_out.load_rejected;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || o_res_if.ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= in_fire;
            end
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || o_res_if.ready) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_fire) begin
                r_out <= res;
            end
        end else if (in_fire) begin
            r_skid <= res;
        end
    end

endmodule

@@ dv/testbench.sv @@
// Testbench for rgb_led_serial_waveform: a tick predictor checks every result transaction.
// Runs directed and random ticks over several APB register settings, with random gaps on both
// streams. Depends on rlsw_pkg, the interfaces in rlsw_if.sv and the RTL top level.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rlsw_pkg::*;

    localparam logic MODE_TICK = 1'b0;
    localparam int   LIMIT     = 200000;

    typedef enum logic [1:0] {PH_IDLE, PH_LEAD, PH_BITS} wave_phase_e;

    typedef struct packed {
        logic             mode;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
    } tick_item_t;

    typedef struct packed {
        logic line;
        logic busy;
        logic rejected;
    } line_sample_t;

    typedef struct packed {
        logic [CFG_W-1:0] period;
        logic [CFG_W-1:0] zero_high;
        logic [CFG_W-1:0] one_high;
    } wave_cfg_t;

    typedef struct packed {
        logic [RGB_W-1:0] colour;
        logic [CNT_W-1:0] bits_left;
        logic [CFG_W-1:0] tick;
        wave_phase_e      phase;
    } wave_state_t;

    localparam wave_state_t WAVE_RESET = '{colour: '0, bits_left: '0, tick: '0, phase: PH_IDLE};

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [PDATA_W-1:0]  pwdata  = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    rlsw_in_if  in_if ();
    rlsw_res_if res_if ();

    rgb_led_serial_waveform u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .i_in_if  (in_if),
        .o_res_if (res_if)
    );

    always #2ns i_clk = ~i_clk;

    wave_cfg_t     wave_cfg;
    wave_state_t   pred_st;
    wave_state_t   plan_st;
    tick_item_t    ticks_to_send[$];
    line_sample_t  line_samples_due[$];
    tick_item_t    tick_on_bus;

    bit src_burst  = 1'b0;
    bit sink_burst = 1'b0;
    int gap_left   = 0;
    int stall_left = 0;
    int cycle_count     = 0;
    int mismatch_count  = 0;
    int samples_checked = 0;
    int loads_started   = 0;
    int loads_rejected  = 0;
    int settings_used   = 0;

    // One tick of the waveform generator; updates st and returns the line sample.
    function automatic line_sample_t waveform_tick(inout wave_state_t st, input wave_cfg_t cfg,
                                                   input tick_item_t t);
        line_sample_t    r;
        logic [CFG_W:0]  nxt;
        logic [CFG_W-1:0] high_ticks;
        logic            bit_val;
        logic            period_done;
        r = '0;
        if (t.mode == MODE_LOAD) begin
            if (st.phase == PH_IDLE) begin
                st.colour    = {t.red, t.green, t.blue};
                st.bits_left = CNT_W'(BITS_PER_LED);
                st.tick      = '0;
                st.phase     = PH_LEAD;
            end else begin
                r.rejected = 1'b1;
            end
        end
        if (st.phase != PH_IDLE) begin
            r.busy = 1'b1;
            if (st.phase == PH_BITS) begin
                bit_val    = st.colour[st.bits_left - 1'b1];
                high_ticks = bit_val ? cfg.one_high : cfg.zero_high;
                r.line     = (st.tick < high_ticks);
            end
            nxt         = {1'b0, st.tick} + 1'b1;
            period_done = (nxt >= {1'b0, cfg.period});
            st.tick     = period_done ? '0 : nxt[CFG_W-1:0];
            if (period_done) begin
                if (st.phase == PH_LEAD) begin
                    st.phase = PH_BITS;
                end else begin
                    st.bits_left = st.bits_left - 1'b1;
                    if (st.bits_left == '0) st.phase = PH_IDLE;
                end
            end
        end
        return r;
    endfunction

    // Input driver: predicts on each accepted transaction, then offers the next tick.
    always @(posedge i_clk) begin
        line_sample_t due;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                due = waveform_tick(pred_st, wave_cfg, tick_on_bus);
                line_samples_due.push_back(due);
                if (tick_on_bus.mode == MODE_LOAD) begin
                    if (due.rejected) loads_rejected++;
                    else loads_started++;
                end
            end
            if (!in_if.valid || in_if.ready) begin
                if (gap_left > 0 || ticks_to_send.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    in_if.valid <= 1'b0;
                end else begin
                    tick_on_bus  = ticks_to_send.pop_front();
                    in_if.valid <= 1'b1;
                    in_if.mode  <= tick_on_bus.mode;
                    in_if.red   <= tick_on_bus.red;
                    in_if.green <= tick_on_bus.green;
                    in_if.blue  <= tick_on_bus.blue;
                    gap_left     = src_burst ? 0 : $urandom_range(0, 13);
                end
            end
        end
    end

    // Result monitor: compares each result transaction with the oldest prediction.
    always @(posedge i_clk) begin
        line_sample_t want;
        line_sample_t got;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                got = '{line: res_if.line_level, busy: res_if.busy_res,
                        rejected: res_if.load_rejected};
                if (line_samples_due.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("%0t: unexpected result line=%b busy=%b rejected=%b",
                                 $realtime, got.line, got.busy, got.rejected);
                    mismatch_count++;
                end else begin
                    want = line_samples_due.pop_front();
                    if (got !== want) begin
                        if (mismatch_count < 10) begin
                            $display("%0t: result %0d mismatch", $realtime, samples_checked);
                            $display("  expected line=%b busy=%b rejected=%b",
                                     want.line, want.busy, want.rejected);
                            $display("  got      line=%b busy=%b rejected=%b",
                                     got.line, got.busy, got.rejected);
                        end
                        mismatch_count++;
                    end
                end
                samples_checked++;
                stall_left = sink_burst ? 0 : $urandom_range(0, 13);
            end
            if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, line_samples_due.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PERIOD_LEN: wave_cfg.period    = value;
            REG_ZERO_HIGH:  wave_cfg.zero_high = value;
            REG_ONE_HIGH:   wave_cfg.one_high  = value;
            default: ;
        endcase
    endtask

    task automatic queue_tick(input tick_item_t t);
        void'(waveform_tick(plan_st, wave_cfg, t));
        ticks_to_send.push_back(t);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (ticks_to_send.size() != 0 || in_if.valid || line_samples_due.size() != 0);
        repeat (2) @(negedge i_clk);
    endtask

    // Mostly complete frames; an occasional load lands mid-frame and gets rejected.
    task automatic queue_random_ticks(input int n);
        tick_item_t       t;
        logic [RGB_W-1:0] colour;
        for (int k = 0; k < n; k++) begin
            if (plan_st.phase == PH_IDLE)
                t.mode = ($urandom_range(0, 3) != 0) ? MODE_LOAD : MODE_TICK;
            else
                t.mode = ($urandom_range(0, 23) == 0) ? MODE_LOAD : MODE_TICK;
            if ($urandom_range(0, 7) == 0)
                colour = $urandom_range(0, 1) ? '1 : '0;
            else
                colour = RGB_W'($urandom);
            {t.red, t.green, t.blue} = colour;
            queue_tick(t);
        end
    endtask

    task automatic run_setting(input logic [CFG_W-1:0] period, input logic [CFG_W-1:0] zero_h,
                               input logic [CFG_W-1:0] one_h, input int n);
        src_burst  = ($urandom_range(0, 3) == 0);
        sink_burst = ($urandom_range(0, 3) == 0);
        write_reg(REG_PERIOD_LEN, period);
        write_reg(REG_ZERO_HIGH, zero_h);
        write_reg(REG_ONE_HIGH, one_h);
        settings_used++;
        @(negedge i_clk);
        queue_random_ticks(n);
        wait_drained();
    endtask

    initial begin
        int p;
        in_if.valid  = 1'b0;
        in_if.mode   = MODE_TICK;
        in_if.red    = '0;
        in_if.green  = '0;
        in_if.blue   = '0;
        res_if.ready = 1'b0;
        wave_cfg = '{period: PERIOD_RST, zero_high: ZERO_RST, one_high: ONE_RST};
        pred_st  = WAVE_RESET;
        plan_st  = WAVE_RESET;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values: idle tick, load all ones, load while busy, plain tick.
        queue_tick(tick_item_t'{MODE_TICK, 8'hFF, 8'hFF, 8'hFF});
        queue_tick(tick_item_t'{MODE_LOAD, 8'hFF, 8'hFF, 8'hFF});
        queue_tick(tick_item_t'{MODE_LOAD, 8'h00, 8'h00, 8'h00});
        queue_tick(tick_item_t'{MODE_TICK, 8'h00, 8'h00, 8'h00});
        wait_drained();
        // Shrinking the period mid lead-in ends it on the next tick.
        run_setting(16'd1, 16'd0, 16'd1, 0);
        queue_tick(tick_item_t'{MODE_TICK, 8'h00, 8'h00, 8'h00});
        queue_tick(tick_item_t'{MODE_LOAD, 8'h80, 8'h00, 8'h01});
        wait_drained();

        run_setting(16'd2, 16'd0, 16'hFFFF, 100);
        run_setting(16'd0, 16'd1, 16'd0, 80);
        run_setting(16'd3, 16'd1, 16'd2, 120);
        run_setting(16'hFFFF, 16'hFFFF, 16'd0, 30);
        run_setting(16'd4, 16'd2, 16'd3, 120);
        run_setting(16'd5, 16'hFFFF, 16'hFFFF, 130);
        run_setting(16'd1, 16'hFFFF, 16'd0, 60);
        for (int k = 0; k < 3; k++) begin
            p = $urandom_range(1, 6);
            run_setting(CFG_W'(p), CFG_W'($urandom_range(0, p + 1)),
                        CFG_W'($urandom_range(0, p + 1)), 90);
        end

        repeat (4) @(negedge i_clk);
        if (line_samples_due.size() != 0) begin
            $display("%0d expected results never arrived", line_samples_due.size());
            mismatch_count++;
        end
        $display("checked %0d tick results over %0d register settings",
                 samples_checked, settings_used);
        $display("frames started %0d, loads refused while busy %0d, mismatches %0d",
                 loads_started, loads_rejected, mismatch_count);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/rlsw_pkg.sv
rtl/rlsw_if.sv
rtl/rgb_led_serial_waveform.sv
dv/testbench.sv
